@@ hw/rtl/bpc_pkg.sv @@
// Package for the button press classifier: item types, event codes and register indexes.
// Used by every module of the block; it depends on nothing else.
package bpc_pkg;

  // Fixed field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEVEL_BITS = 4;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CLICK_W    = 8;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 4;

  // At most this many events leave the block for one tick.
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  // Reset values of the timing registers, in ms.
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd800;
  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RESET = 16'd400;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_PRESS = 4'd1;

  // Press type codes.
  localparam logic [TYPE_W-1:0] PRESS_SINGLE = 2'd1;
  localparam logic [TYPE_W-1:0] PRESS_DOUBLE = 2'd2;
  localparam logic [TYPE_W-1:0] PRESS_LONG   = 2'd3;

  // One input item: a sampling tick.
  typedef struct packed {
    logic [TIME_W-1:0]     now_ms;
    logic [LEVEL_BITS-1:0] button_levels;
  } in_item_t;

  // One result item: a button event.
  typedef struct packed {
    logic [BTN_W-1:0]  button_number;
    logic [TYPE_W-1:0] press_kind;
    logic              last_event;
  } out_item_t;

  // Events that one button raises for one tick.
  typedef struct packed {
    logic long_ev;
    logic click_ev;
    logic double_ev;
  } lane_ev_t;

  // Status of the event serializer seen by the input stage.
  typedef struct packed {
    logic free;
    logic busy;
  } ser_status_t;

endpackage

@@ hw/rtl/button_press_classifier.sv @@
// Button press classifier: input register, per-button lanes and event serializer.
// Depends on bpc_pkg, bpc_lane and bpc_serializer.
//
// Usage: each input item is one sampling tick with a ms timestamp and the
// active-low button levels. The block answers with zero or more event items
// (button number, press type, last-event flag); the last event of a tick has
// last_event set, and a tick without events produces no item.
// Channels use valid and stall: an item moves when valid is high and stall low.
// Timing: a tick is registered at the input, decided there, loaded into the event
// register, and its first event passes the output register to out_valid_o.
// Throughput, receiver not stalling: one tick per cycle if it raises no event,
// otherwise one cycle per event, paced by the serializer's single result port.
// When the receiver stalls, the output register and the event register hold,
// and in_stall_o rises once the input register holds a tick it cannot pass on.
// Configuration writes (long press and double press windows) are always
// accepted and must only be made while the block is idle.
// Reset clears all button state and loads 800 ms and 400 ms into the windows.
module button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bpc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bpc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bpc_pkg::CFG_W-1:0]      cfg_data_i
);

  logic                          in_valid_q, in_valid_d;
  bpc_pkg::in_item_t             in_data_q;
  logic                          in_load, advance, any_ev;
  logic [bpc_pkg::CFG_W-1:0]     long_ms_q, double_ms_q;
  bpc_pkg::lane_ev_t             lane_ev [NUM_BUTTONS];
  bpc_pkg::ser_status_t          ser_status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q   <= bpc_pkg::LONG_PRESS_RESET;
      double_ms_q <= bpc_pkg::DOUBLE_PRESS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bpc_pkg::REG_LONG_PRESS) begin
        long_ms_q <= cfg_data_i;
      end
      if (cfg_index_i == bpc_pkg::REG_DOUBLE_PRESS) begin
        double_ms_q <= cfg_data_i;
      end
    end
  end

  // Input register; a tick moves on when the serializer can take its events.
  assign advance    = in_valid_q & ser_status.free;
  assign in_stall_o = in_valid_q & ~ser_status.free;
  assign in_load    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= in_data_i;
    end
  end

  // One lane per button; buttons without a level bit read as released.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic pressed;
    if (b < bpc_pkg::LEVEL_BITS) begin : g_pin
      assign pressed = ~in_data_q.button_levels[b];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    bpc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .pressed_i   (pressed),
      .now_ms_i    (in_data_q.now_ms),
      .long_ms_i   (long_ms_q),
      .double_ms_i (double_ms_q),
      .ev_o        (lane_ev[b])
    );
  end

  // Any event raised by the tick in the input register.
  always_comb begin
    any_ev = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      any_ev = any_ev | lane_ev[b].long_ev | lane_ev[b].click_ev;
    end
  end

  bpc_serializer #(
    .NumButtons (NUM_BUTTONS)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .ev_i        (lane_ev),
    .status_o    (ser_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Every result carries a real press type.
  a_type_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.press_kind != '0))
    else $error("result item with empty press type");

  // A tick that raises events leaves the serializer busy.
  a_events_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && any_ev) |=> ser_status.busy)
    else $error("events of a tick were lost");

  // A stalled tick stays in the input register.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled tick left the input register");

  // Nothing is shown on the output while nothing was pending.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ser_status.busy && !out_valid_o) |=> !out_valid_o)
    else $error("result item without a pending event");
`endif

endmodule

@@ hw/rtl/bpc_lane.sv @@
// One button lane: held flag, press time and click count, plus the event decision.
// Depends on bpc_pkg for the lane event type and field widths.
module bpc_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        pressed_i,
  input  logic [bpc_pkg::TIME_W-1:0]  now_ms_i,
  input  logic [bpc_pkg::CFG_W-1:0]   long_ms_i,
  input  logic [bpc_pkg::CFG_W-1:0]   double_ms_i,
  output bpc_pkg::lane_ev_t           ev_o
);

  logic                          held_q, held_d;
  logic [bpc_pkg::TIME_W-1:0]    start_q, start_d;
  logic [bpc_pkg::CLICK_W-1:0]   clicks_q, clicks_d, clicks_mid;
  logic                          press_now, release_now;
  logic [bpc_pkg::TIME_W-1:0]    hold_time, since_press;
  logic                          long_ev, click_ev;

  // Edge detection against the held flag.
  assign press_now   = pressed_i & ~held_q;
  assign release_now = ~pressed_i & held_q;
  assign held_d      = pressed_i;
  assign start_d     = press_now ? now_ms_i : start_q;

  // Hold time of a release, modulo 2^32.
  assign hold_time = now_ms_i - start_q;
  assign long_ev   = release_now && (hold_time > {16'd0, long_ms_i});

  // A short release adds a click; the count saturates.
  always_comb begin
    clicks_mid = clicks_q;
    if (release_now && !long_ev && (clicks_q != '1)) begin
      clicks_mid = clicks_q + 1'b1;
    end
  end

  // Pending clicks are reported once the window since the last press is over.
  assign since_press = now_ms_i - start_d;
  assign click_ev    = (clicks_mid != '0) && (since_press > {16'd0, double_ms_i});
  assign clicks_d    = click_ev ? '0 : clicks_mid;

  assign ev_o.long_ev   = long_ev;
  assign ev_o.click_ev  = click_ev;
  assign ev_o.double_ev = (clicks_mid != bpc_pkg::CLICK_W'(1));

  // Lane state advances once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      start_q  <= '0;
      clicks_q <= '0;
    end else if (en_i) begin
      held_q   <= held_d;
      start_q  <= start_d;
      clicks_q <= clicks_d;
    end
  end

endmodule

@@ hw/rtl/bpc_serializer.sv @@
// Event serializer: holds a tick's events, hands out one item a cycle unless stalled.
// Depends on bpc_pkg for the lane event, status and result item types.
module bpc_serializer #(
  parameter int unsigned NumButtons = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  bpc_pkg::lane_ev_t     ev_i [NumButtons],
  output bpc_pkg::ser_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bpc_pkg::out_item_t    out_data_o
);

  localparam int unsigned EvBits = 2 * NumButtons;

  logic [EvBits-1:0]               mask_q, mask_d, mask_new, sel_oh, rest;
  logic [NumButtons-1:0]           dbl_q, dbl_d, dbl_new;
  logic [bpc_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  bpc_pkg::out_item_t              out_data_q, out_data_d;
  logic [bpc_pkg::BTN_W-1:0]       sel_btn;
  logic [bpc_pkg::TYPE_W-1:0]      sel_type;
  logic                            busy, out_load, pop, last;

  // Events of a new tick, ordered long before click for each button.
  always_comb begin
    for (int b = 0; b < NumButtons; b++) begin
      mask_new[2*b]   = ev_i[b].long_ev;
      mask_new[2*b+1] = ev_i[b].click_ev;
      dbl_new[b]      = ev_i[b].double_ev;
    end
  end

  // Pick the lowest pending event.
  always_comb begin
    sel_oh   = '0;
    sel_btn  = '0;
    sel_type = bpc_pkg::PRESS_SINGLE;
    for (int i = EvBits - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_oh    = '0;
        sel_oh[i] = 1'b1;
        sel_btn   = bpc_pkg::BTN_W'((i / 2) + 1);
        if ((i % 2) == 0) begin
          sel_type = bpc_pkg::PRESS_LONG;
        end else if (dbl_q[i/2]) begin
          sel_type = bpc_pkg::PRESS_DOUBLE;
        end else begin
          sel_type = bpc_pkg::PRESS_SINGLE;
        end
      end
    end
  end

  assign busy     = (mask_q != '0);
  assign out_load = ~out_valid_q | ~out_stall_i;
  assign pop      = busy & out_load;
  assign rest     = mask_q & ~sel_oh;
  // The tick ends when nothing is left or the event limit is reached.
  assign last     = (rest == '0) || (cnt_q == bpc_pkg::CNT_W'(bpc_pkg::MAX_RESULTS - 1));

  assign status_o.busy = busy;
  assign status_o.free = ~busy | (pop & last);

  // Next contents of the event register.
  always_comb begin
    mask_d = mask_q;
    dbl_d  = dbl_q;
    cnt_d  = cnt_q;
    if (pop) begin
      mask_d = last ? '0 : rest;
      cnt_d  = cnt_q + 1'b1;
    end
    if (load_i) begin
      mask_d = mask_new;
      dbl_d  = dbl_new;
      cnt_d  = '0;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d              = pop;
      out_data_d.button_number = sel_btn;
      out_data_d.press_kind    = sel_type;
      out_data_d.last_event    = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dbl_q      <= dbl_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
